### sv/gwfm_pkg.sv
// shared constants and field widths for the grid wall falloff map
package gwfm_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int LEVEL_W  = 15;
    localparam int RADIUS_W = 6;
    localparam int DIM_W    = 7;
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 15;

    localparam int PROD_W    = LEVEL_W + RADIUS_W;
    localparam int DIV_CNT_W = $clog2(PROD_W + 1);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WALL_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 2'd3;

    localparam logic [LEVEL_W-1:0]  RST_WALL_LEVEL = 15'd100;
    localparam logic [RADIUS_W-1:0] RST_RADIUS     = 6'd7;
    localparam logic [DIM_W-1:0]    RST_WIDTH      = 7'd64;
    localparam logic [DIM_W-1:0]    RST_HEIGHT     = 7'd64;

endpackage

### sv/grid_wall_falloff_map.sv
// grid wall falloff map: cell level store, falloff sequencer and shared divider
// results: write, spare or zero-radius requests go straight to S_DONE; a read passes S_RDW first
// run: per step of the radius a multiply, a serial divide, then a check of each cell and its neighbours
// one request at a time: the level store (one read, one write port) and the serial divider set the rate
// after reset the store is cleared one cell a cycle, all MAX_WIDTH*MAX_HEIGHT cells,
// while no request is taken; configuration returns to its reset values at once
module grid_wall_falloff_map
    import gwfm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // cmd, cell_index, is_wall, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // cell_level, op_done, zero pad
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int CMPW  = (CW > INDEX_W) ? CW : INDEX_W;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RDW    = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_CTR    = 4'd5;
    localparam logic [3:0] S_CTRCHK = 4'd6;
    localparam logic [3:0] S_NB     = 4'd7;
    localparam logic [3:0] S_NBLAST = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    localparam logic [1:0] OFS_LOW  = 2'd0;
    localparam logic [1:0] OFS_HIGH = 2'd2;

    // configuration
    logic [LEVEL_W-1:0]  wall_level_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wall_level_reg <= RST_WALL_LEVEL;
            radius_reg     <= RST_RADIUS;
            width_reg      <= RST_WIDTH;
            height_reg     <= RST_HEIGHT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WALL_LEVEL: wall_level_reg <= cfg_wdata[LEVEL_W-1:0];
                REG_RADIUS:     radius_reg     <= cfg_wdata[RADIUS_W-1:0];
                REG_WIDTH:      width_reg      <= cfg_wdata[DIM_W-1:0];
                REG_HEIGHT:     height_reg     <= cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // saturated grid size
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [CW-1:0] cell_count;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(height_reg);
        end
        cell_count = CW'(w_eff) * CW'(h_eff);
    end

    // input fields
    logic [CMD_W-1:0]   s_cmd;
    logic [INDEX_W-1:0] s_idx;
    logic               s_wall;
    logic               in_grid;
    logic               accept;

    assign s_cmd   = s_tdata[CMD_W-1:0];
    assign s_idx   = s_tdata[CMD_W+INDEX_W-1:CMD_W];
    assign s_wall  = s_tdata[CMD_W+INDEX_W];
    assign in_grid = CMPW'(s_idx) < CMPW'(cell_count);

    // control and datapath registers
    logic [3:0]           state_reg, state_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [AW-1:0]        i_reg, i_next;
    logic [XW-1:0]        x_reg, x_next;
    logic [YW-1:0]        y_reg, y_next;
    logic [1:0]           nbx_reg, nbx_next;
    logic [1:0]           nby_reg, nby_next;
    logic                 pend_reg, pend_next;
    logic [RADIUS_W-1:0]  k_reg, k_next;
    logic [LEVEL_W-1:0]   hi_reg, hi_next;
    logic [PROD_W-1:0]    quo_reg, quo_next;
    logic [RADIUS_W-1:0]  rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 rd_ok_reg, rd_ok_next;
    logic [LEVEL_W-1:0]   res_level_reg, res_level_next;
    logic [CMD_W-1:0]     res_op_reg, res_op_next;
    logic                 m_valid_reg, m_valid_next;
    logic [LEVEL_W-1:0]   m_level_reg, m_level_next;
    logic [CMD_W-1:0]     m_op_reg, m_op_next;

    // level store
    logic [LEVEL_W-1:0] mem [CELLS];
    logic [LEVEL_W-1:0] rdata_reg;
    logic [AW-1:0]      raddr;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [LEVEL_W-1:0] wdata;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // neighbour address with edge clamping
    logic          x_last, y_last, cell_last;
    logic          ox_neg, ox_pos, oy_neg, oy_pos, nb_self, nb_last;
    logic [AW-1:0] nb_addr, x_term, y_term;

    // shared serial divider step
    logic [RADIUS_W:0] rem_shift;
    logic              div_ge;

    always_comb begin
        x_last    = WW'(x_reg) == (w_eff - 1'b1);
        y_last    = HW'(y_reg) == (h_eff - 1'b1);
        cell_last = x_last && y_last;
        ox_neg    = (nbx_reg == OFS_LOW) && (x_reg != '0);
        ox_pos    = (nbx_reg == OFS_HIGH) && !x_last;
        oy_neg    = (nby_reg == OFS_LOW) && (y_reg != '0);
        oy_pos    = (nby_reg == OFS_HIGH) && !y_last;
        nb_self   = !ox_neg && !ox_pos && !oy_neg && !oy_pos;
        nb_last   = (nbx_reg == OFS_HIGH) && (nby_reg == OFS_HIGH);
        x_term    = ox_neg ? '1 : (ox_pos ? AW'(1) : '0);
        y_term    = oy_neg ? (AW'(0) - AW'(w_eff)) : (oy_pos ? AW'(w_eff) : '0);
        nb_addr   = i_reg + y_term + x_term;
        rem_shift = {rem_reg, quo_reg[PROD_W-1]};
        div_ge    = rem_shift >= (RADIUS_W+1)'(radius_reg);
    end

    assign accept = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        i_next         = i_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        nbx_next       = nbx_reg;
        nby_next       = nby_reg;
        pend_next      = pend_reg;
        k_next         = k_reg;
        hi_next        = hi_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        rd_ok_next     = rd_ok_reg;
        res_level_next = res_level_reg;
        res_op_next    = res_op_reg;
        m_valid_next   = m_valid_reg;
        m_level_next   = m_level_reg;
        m_op_next      = m_op_reg;
        raddr          = i_reg;
        we             = 1'b0;
        waddr          = i_reg;
        wdata          = quo_reg[LEVEL_W-1:0];

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR: begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(CELLS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                raddr = AW'(CMPW'(s_idx));
                if (accept) begin
                    res_level_next = '0;
                    res_op_next    = s_cmd;
                    rd_ok_next     = in_grid;
                    case (s_cmd)
                        CMD_WRITE: begin
                            we         = in_grid;
                            waddr      = AW'(CMPW'(s_idx));
                            wdata      = s_wall ? wall_level_reg : '0;
                            state_next = S_DONE;
                        end
                        CMD_RUN: begin
                            hi_next = wall_level_reg;
                            k_next  = radius_reg - 1'b1;
                            if (radius_reg == '0) begin
                                state_next = S_DONE;
                            end else begin
                                state_next = S_MUL;
                            end
                        end
                        CMD_READ: begin
                            state_next = S_RDW;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RDW: begin
                res_level_next = rd_ok_reg ? rdata_reg : '0;
                state_next     = S_DONE;
            end
            S_MUL: begin
                quo_next     = PROD_W'(wall_level_reg) * PROD_W'(k_reg);
                rem_next     = '0;
                div_cnt_next = DIV_CNT_W'(PROD_W);
                state_next   = S_DIV;
            end
            S_DIV: begin
                if (div_ge) begin
                    rem_next = RADIUS_W'(rem_shift - (RADIUS_W+1)'(radius_reg));
                    quo_next = {quo_reg[PROD_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift[RADIUS_W-1:0];
                    quo_next = {quo_reg[PROD_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(1)) begin
                    i_next     = '0;
                    x_next     = '0;
                    y_next     = '0;
                    state_next = S_CTR;
                end
            end
            S_CTR: begin
                raddr      = i_reg;
                state_next = S_CTRCHK;
            end
            S_CTRCHK: begin
                if (rdata_reg >= hi_reg) begin
                    state_next = S_NBLAST;
                    pend_next  = 1'b0;
                end else begin
                    nbx_next   = OFS_LOW;
                    nby_next   = OFS_LOW;
                    pend_next  = 1'b0;
                    state_next = S_NB;
                end
            end
            S_NB: begin
                raddr     = nb_addr;
                pend_next = !nb_self;
                if (pend_reg && (rdata_reg == hi_reg)) begin
                    we         = 1'b1;
                    pend_next  = 1'b0;
                    state_next = S_NBLAST;
                end else if (nb_last) begin
                    state_next = S_NBLAST;
                end else if (nby_reg == OFS_HIGH) begin
                    nby_next = OFS_LOW;
                    nbx_next = nbx_reg + 1'b1;
                end else begin
                    nby_next = nby_reg + 1'b1;
                end
            end
            S_NBLAST: begin
                we        = pend_reg && (rdata_reg == hi_reg);
                pend_next = 1'b0;
                if (cell_last) begin
                    if (k_reg == '0) begin
                        state_next = S_DONE;
                    end else begin
                        hi_next    = quo_reg[LEVEL_W-1:0];
                        k_next     = k_reg - 1'b1;
                        state_next = S_MUL;
                    end
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_CTR;
                    if (x_last) begin
                        x_next = '0;
                        y_next = y_reg + 1'b1;
                    end else begin
                        x_next = x_reg + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_level_next = res_level_reg;
                    m_op_next    = res_op_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg         <= i_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        nbx_reg       <= nbx_next;
        nby_reg       <= nby_next;
        k_reg         <= k_next;
        hi_reg        <= hi_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        div_cnt_reg   <= div_cnt_next;
        rd_ok_reg     <= rd_ok_next;
        res_level_reg <= res_level_next;
        res_op_reg    <= res_op_next;
        m_level_reg   <= m_level_next;
        m_op_reg      <= m_op_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - LEVEL_W - CMD_W){1'b0}}, m_op_reg, m_level_reg};

endmodule
